### hdl/brms_pkg.sv
// Shared widths and types for the block true-RMS design.
// No dependencies; imported by every module under hdl.
package brms_pkg;

    localparam int SAMPLE_W    = 16;                     // sample width
    localparam int LEN_W       = 16;                     // block length / count width
    localparam int SQ_W        = 2 * SAMPLE_W;           // width of one square
    localparam int SUM_W       = SQ_W + LEN_W - 2;       // running sum, cannot overflow
    localparam int MEAN_W      = SQ_W - 1;               // mean is at most 2^(2W-2)
    localparam int ROOT_W      = SAMPLE_W;               // result width
    localparam int ROOT_TOP    = 2 * (ROOT_W - 1);       // first trial bit of the root
    localparam int STEP_W      = $clog2(SUM_W);          // divider step counter
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = QPTR_W + 1;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

    // One finished block handed from the front to the back
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [LEN_W-1:0] count;
    } blk_t;

endpackage

### hdl/brms_front.sv
// Front end: takes samples, squares them, accumulates and counts per block.
// Depends on brms_pkg; pushes finished blocks into brms_queue.
module brms_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [brms_pkg::LEN_W-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [brms_pkg::SAMPLE_W-1:0] s_tdata,
    input  logic [brms_pkg::QLVL_W-1:0] q_level,
    output logic                        push,
    output brms_pkg::blk_t              push_blk
);
    import brms_pkg::*;

    logic [LEN_W-1:0]    len_reg;
    logic [LEN_W-1:0]    taken_reg, taken_next;
    logic [SQ_W-1:0]     sq_reg;
    logic                sq_valid_reg;
    logic                sq_last_reg;
    logic [LEN_W-1:0]    sq_count_reg;
    logic [SUM_W-1:0]    sum_reg, sum_next;

    logic                accept;
    logic [LEN_W-1:0]    len_eff;
    logic [LEN_W-1:0]    count;
    logic                is_last;
    logic [SAMPLE_W-1:0] mag;
    logic [SUM_W-1:0]    sum_acc;

    // keep room for the block that may still be in the square stage
    assign s_tready = (q_level + QLVL_W'(sq_valid_reg & sq_last_reg)) < QLVL_W'(QUEUE_DEPTH);
    assign accept   = s_tvalid & s_tready;

    assign len_eff  = (len_reg == '0) ? LEN_W'(1) : len_reg;
    assign count    = taken_reg + LEN_W'(1);
    assign is_last  = count >= len_eff;
    assign mag      = s_tdata[SAMPLE_W-1] ? (~s_tdata + SAMPLE_W'(1)) : s_tdata;

    assign sum_acc  = sum_reg + SUM_W'(sq_reg);

    assign push           = sq_valid_reg & sq_last_reg;
    assign push_blk.sum   = sum_acc;
    assign push_blk.count = sq_count_reg;

    always_comb
    begin
        taken_next = taken_reg;
        if (accept)
        begin
            taken_next = is_last ? '0 : count;
        end
        sum_next = sum_reg;
        if (sq_valid_reg)
        begin
            sum_next = sq_last_reg ? '0 : sum_acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= LEN_RESET;
            taken_reg    <= '0;
            sq_valid_reg <= 1'b0;
            sq_last_reg  <= 1'b0;
            sum_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg <= cfg_wdata;
            end
            taken_reg    <= taken_next;
            sq_valid_reg <= accept;
            sq_last_reg  <= accept & is_last;
            sum_reg      <= sum_next;
        end
    end

    // square stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sq_reg       <= SQ_W'(mag) * SQ_W'(mag);
            sq_count_reg <= count;
        end
    end

endmodule

### hdl/brms_queue.sv
// Short queue of finished blocks between the front end and the back end.
// Depends on brms_pkg (blk_t, QUEUE_DEPTH).
module brms_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  brms_pkg::blk_t              push_blk,
    input  logic                        pop,
    output logic                        q_valid,
    output brms_pkg::blk_t              q_blk,
    output logic [brms_pkg::QLVL_W-1:0] q_level
);
    import brms_pkg::*;

    blk_t              store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QLVL_W-1:0] level_reg;
    logic              do_pop;

    assign q_valid = level_reg != '0;
    assign q_blk   = store_reg[rd_ptr_reg];
    assign q_level = level_reg;
    assign do_pop  = pop & q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !do_pop)
            begin
                level_reg <= level_reg + QLVL_W'(1);
            end
            else if (do_pop && !push)
            begin
                level_reg <= level_reg - QLVL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_blk;
        end
    end

endmodule

### hdl/brms_back.sv
// Back end: per block, divide the sum by the count one bit a cycle, then take
// the floor square root two bits a cycle. Depends on brms_pkg.
module brms_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  brms_pkg::blk_t                q_blk,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [brms_pkg::ROOT_W-1:0]   m_tdata
);
    import brms_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_ROOT, ST_HOLD} state_t;

    state_t             state_reg;
    logic [SUM_W-1:0]   dvd_reg;     // dividend, quotient shifts in from the bottom
    logic [LEN_W-1:0]   div_reg;
    logic [LEN_W-1:0]   rem_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [MEAN_W-1:0]  v_reg;
    logic [MEAN_W-1:0]  res_reg;
    logic [MEAN_W-1:0]  bit_reg;
    logic [ROOT_W-1:0]  rms_reg;

    logic [LEN_W:0]     rem_sh;
    logic               q_bit;
    logic [LEN_W-1:0]   rem_new;
    logic [SUM_W-1:0]   dvd_new;
    logic [MEAN_W:0]    trial;
    logic               take;
    logic [MEAN_W-1:0]  v_new;
    logic [MEAN_W-1:0]  res_new;

    assign pop      = (state_reg == ST_IDLE) & q_valid;
    assign m_tvalid = state_reg == ST_HOLD;
    assign m_tdata  = rms_reg;

    // restoring division step
    assign rem_sh  = {rem_reg, dvd_reg[SUM_W-1]};
    assign q_bit   = rem_sh >= {1'b0, div_reg};
    assign rem_new = q_bit ? LEN_W'(rem_sh - {1'b0, div_reg}) : rem_sh[LEN_W-1:0];
    assign dvd_new = {dvd_reg[SUM_W-2:0], q_bit};

    // square root step
    assign trial   = {1'b0, res_reg} + {1'b0, bit_reg};
    assign take    = {1'b0, v_reg} >= trial;
    assign v_new   = take ? MEAN_W'({1'b0, v_reg} - trial) : v_reg;
    assign res_new = take ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= ST_DIV;
                        step_reg  <= '0;
                        dvd_reg   <= q_blk.sum;
                        div_reg   <= q_blk.count;
                        rem_reg   <= '0;
                    end
                end
                ST_DIV:
                begin
                    dvd_reg  <= dvd_new;
                    rem_reg  <= rem_new;
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(SUM_W - 1))
                    begin
                        state_reg <= ST_ROOT;
                        v_reg     <= dvd_new[MEAN_W-1:0];
                        res_reg   <= '0;
                        bit_reg   <= MEAN_W'(1) << ROOT_TOP;
                    end
                end
                ST_ROOT:
                begin
                    v_reg   <= v_new;
                    res_reg <= res_new;
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                    begin
                        state_reg <= ST_HOLD;
                        rms_reg   <= res_new[ROOT_W-1:0];
                    end
                end
                ST_HOLD:
                begin
                    if (m_tready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/block_true_rms.sv
// Top level of the block true-RMS engine.
// Depends on brms_pkg, brms_front, brms_queue and brms_back.
//
// Usage
//   Slave stream (s_tvalid/s_tready/s_tdata) carries one signed sample per
//   word. Each sample is squared and added to a running sum; once the number
//   of samples in the block reaches the block length, the master stream
//   (m_tvalid/m_tready/m_tdata) delivers floor(sqrt(floor(sum / count))).
//   cfg_we/cfg_wdata write the block length (reset 1024; zero acts as one).
//   Write it only while the block is idle.
// Throughput
//   Samples are taken one per cycle while s_tready is high. Per block the back
//   end loads the block, divides the sum by the count, takes the root and then
//   hands the result over; it takes the next block only once that is done.
//   The front stalls only once four finished blocks wait, counting the one in
//   the square stage.
// Reset and stalls
//   Reset clears the sum, the count and the queue and restores the length. A
//   stalled receiver holds the result; the front keeps accepting samples until
//   the queue fills, then drops s_tready.
module block_true_rms (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [brms_pkg::LEN_W-1:0]    cfg_wdata,   // block_length
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [brms_pkg::SAMPLE_W-1:0] s_tdata,     // [15:0] sample
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [brms_pkg::ROOT_W-1:0]   m_tdata      // [15:0] rms_value
);
    import brms_pkg::*;

    logic              push;
    blk_t              push_blk;
    logic              pop;
    logic              q_valid;
    blk_t              q_blk;
    logic [QLVL_W-1:0] q_level;

    // square and accumulate, close blocks
    brms_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_level   (q_level),
        .push      (push),
        .push_blk  (push_blk)
    );

    // hold finished blocks while the back end is busy
    brms_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_blk (push_blk),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_blk    (q_blk),
        .q_level  (q_level)
    );

    // divide, root and present the result
    brms_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_blk    (q_blk),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
